// ===== rtl/bu_pkg.sv =====
// Shared types, widths and defaults for the bilinear upscaler.
package bu_pkg;

    localparam int MAX_COLS_DEF  = 64;
    localparam int MAX_ROWS_DEF  = 64;
    localparam int MAX_SCALE_DEF = 8;

    localparam int PIX_W     = 8;
    localparam int SCALE_W   = 4;
    localparam int DIM_W     = 7;
    localparam int DIM_CMP_W = 9;
    localparam int COORD_W   = 9;
    localparam int CFG_IDX_W = 3;

    localparam int MUL_X_W = 10;
    localparam int MUL_Y_W = 8;
    localparam int PROD_W  = 19;
    localparam int SUM_W   = 18;
    localparam int DIV_W   = 17;
    localparam int QBITS   = 8;

    localparam logic [SCALE_W-1:0] RST_SCALE = 4'd4;
    localparam logic [DIM_W-1:0]   RST_DIM   = 7'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_X = 3'd0,
        CFG_SCALE_Y = 3'd1,
        CFG_IN_COLS = 3'd2,
        CFG_IN_ROWS = 3'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_MUL_R,
        ST_MUL_K,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/bilinear_upscaler.sv =====
// Bilinear upscaler: line store, setup multiplier, shared restoring divider.
// A pixel that closes no cell stalls the input only through ST_FETCH. A pixel that closes a cell keeps
// the input stalled until all its results are out: 6 setup steps on the shared multiplier,
// then per result one load, 8 divider steps and one output step (more under stall).
// The first result of a cell is registered in its first output step.
// Synchronous active-low reset; registers return to 4, 4, 16, 16; line store not cleared.
module bilinear_upscaler #(
    parameter int MAX_COLS  = bu_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = bu_pkg::MAX_ROWS_DEF,
    parameter int MAX_SCALE = bu_pkg::MAX_SCALE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bu_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bu_pkg::PIX_W-1:0]     i_pixel,
    input  logic                         i_frame_start,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bu_pkg::PIX_W-1:0]     o_value,
    output logic [bu_pkg::COORD_W-1:0]   o_out_row,
    output logic [bu_pkg::COORD_W-1:0]   o_out_col,
    output logic                         o_last_of_cell,
    output logic                         o_last_of_frame
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int RCW  = $clog2(MAX_ROWS);
    localparam int CLW  = $clog2(MAX_COLS + 1);
    localparam int RLW  = $clog2(MAX_ROWS + 1);
    localparam int DCW  = bu_pkg::DIM_CMP_W;
    localparam int SW   = bu_pkg::SCALE_W;
    localparam int SW1  = bu_pkg::SCALE_W + 1;
    localparam int XW   = bu_pkg::MUL_X_W;
    localparam int YW   = bu_pkg::MUL_Y_W;
    localparam int UW   = bu_pkg::SUM_W;
    localparam int DW   = bu_pkg::DIV_W;
    localparam int QW   = bu_pkg::QBITS;
    localparam int BW   = $clog2(bu_pkg::QBITS);
    localparam int PW   = bu_pkg::PIX_W;
    localparam int KW   = bu_pkg::COORD_W;

    bu_pkg::t_state r_state, n_state;

    logic [SW-1:0]              r_scale_x, r_scale_y;
    logic [bu_pkg::DIM_W-1:0]   r_in_cols, r_in_rows;

    logic [RCW-1:0]             r_row;
    logic [CW-1:0]              r_col;
    logic [PW-1:0]              r_above_left, r_left;
    logic                       r_ovalid;

    logic [PW-1:0]              r_line [MAX_COLS];
    logic [PW-1:0]              r_above;

    logic [PW-1:0]              r_pa, r_pc, r_pd;
    logic [RCW-1:0]             r_crow;
    logic [CW-1:0]              r_ccol;
    logic                       r_fend;
    logic                       r_has_cell;
    logic [YW-1:0]              r_s;
    logic signed [UW-1:0]       r_sum, r_rowsum, r_dlt, r_rho, r_ddl;
    logic [KW-1:0]              r_orow, r_ocol;
    logic [SW-1:0]              r_r, r_c;
    logic [DW-1:0]              r_rem, r_dsh;
    logic [QW-1:0]              r_q;
    logic [BW-1:0]              r_bit;

    logic [PW-1:0]              r_value;
    logic [KW-1:0]              r_out_row, r_out_col;
    logic                       r_last_cell, r_last_frame;

    logic [SW1-1:0]             sx_w, sy_w;
    logic [SW-1:0]              sx_c, sy_c;
    logic [DCW-1:0]             cols_w, rows_w;
    logic [CLW-1:0]             cols_c;
    logic [RLW-1:0]             rows_c;

    logic                       restart, accept, has_cell, at_end;
    logic [RCW-1:0]             eff_row, n_row;
    logic [CW-1:0]              eff_col, n_col;
    logic [CLW-1:0]             col_inc;
    logic [RLW-1:0]             row_inc;

    logic signed [XW-1:0]       mul_x;
    logic [YW-1:0]              mul_y;
    logic signed [bu_pkg::PROD_W-1:0] prod;
    logic signed [XW-1:0]       px_a, px_b, px_c, px_d;

    logic                       out_load;
    logic                       row_end, cell_last;
    logic signed [UW-1:0]       rowsum_next;

    // effective register values
    always_comb begin
        sx_w = {1'b0, r_scale_x};
        if (sx_w == '0) begin
            sx_w = SW1'(1);
        end else if (sx_w > SW1'(MAX_SCALE)) begin
            sx_w = SW1'(MAX_SCALE);
        end
        sy_w = {1'b0, r_scale_y};
        if (sy_w == '0) begin
            sy_w = SW1'(1);
        end else if (sy_w > SW1'(MAX_SCALE)) begin
            sy_w = SW1'(MAX_SCALE);
        end
        cols_w = DCW'(r_in_cols);
        if (cols_w < DCW'(2)) begin
            cols_w = DCW'(2);
        end else if (cols_w > DCW'(MAX_COLS)) begin
            cols_w = DCW'(MAX_COLS);
        end
        rows_w = DCW'(r_in_rows);
        if (rows_w < DCW'(2)) begin
            rows_w = DCW'(2);
        end else if (rows_w > DCW'(MAX_ROWS)) begin
            rows_w = DCW'(MAX_ROWS);
        end
        sx_c   = sx_w[SW-1:0];
        sy_c   = sy_w[SW-1:0];
        cols_c = CLW'(cols_w);
        rows_c = RLW'(rows_w);
    end

    // input position
    always_comb begin
        restart  = i_frame_start || (RLW'(r_row) >= rows_c) || (CLW'(r_col) >= cols_c);
        eff_row  = restart ? '0 : r_row;
        eff_col  = restart ? '0 : r_col;
        has_cell = (eff_row != '0) && (eff_col != '0);
        at_end   = (RLW'(eff_row) == rows_c - RLW'(1)) && (CLW'(eff_col) == cols_c - CLW'(1));
        col_inc  = CLW'(eff_col) + CLW'(1);
        row_inc  = RLW'(eff_row) + RLW'(1);
        if (col_inc >= cols_c) begin
            n_col = '0;
            n_row = (row_inc >= rows_c) ? '0 : RCW'(row_inc);
        end else begin
            n_col = CW'(col_inc);
            n_row = eff_row;
        end
    end

    assign px_a = XW'(r_pa);
    assign px_b = XW'(r_above);
    assign px_c = XW'(r_pc);
    assign px_d = XW'(r_pd);

    assign prod = mul_x * $signed({1'b0, mul_y});

    assign row_end     = (r_c == sx_c - SW'(1));
    assign cell_last   = row_end && (r_r == sy_c - SW'(1));
    assign rowsum_next = r_rowsum + r_rho;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bu_pkg::ST_IDLE:  if (accept) n_state = bu_pkg::ST_FETCH;
            bu_pkg::ST_FETCH: n_state = r_has_cell ? bu_pkg::ST_MUL_A : bu_pkg::ST_IDLE;
            bu_pkg::ST_MUL_A: n_state = bu_pkg::ST_MUL_B;
            bu_pkg::ST_MUL_B: n_state = bu_pkg::ST_MUL_C;
            bu_pkg::ST_MUL_C: n_state = bu_pkg::ST_MUL_R;
            bu_pkg::ST_MUL_R: n_state = bu_pkg::ST_MUL_K;
            bu_pkg::ST_MUL_K: n_state = bu_pkg::ST_LOAD;
            bu_pkg::ST_LOAD:  n_state = bu_pkg::ST_DIV;
            bu_pkg::ST_DIV:   if (r_bit == '0) n_state = bu_pkg::ST_OUT;
            bu_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = cell_last ? bu_pkg::ST_IDLE : bu_pkg::ST_LOAD;
                end
            end
            default:          n_state = bu_pkg::ST_IDLE;
        endcase
    end

    // state decode
    always_comb begin
        o_stall  = (r_state != bu_pkg::ST_IDLE);
        out_load = (r_state == bu_pkg::ST_OUT) && (!r_ovalid || !i_stall);
        mul_x    = '0;
        mul_y    = '0;
        case (r_state)
            bu_pkg::ST_FETCH: begin
                mul_x = XW'(sx_c);
                mul_y = YW'(sy_c);
            end
            bu_pkg::ST_MUL_A: begin
                mul_x = px_a;
                mul_y = r_s;
            end
            bu_pkg::ST_MUL_B: begin
                mul_x = px_b - px_a;
                mul_y = YW'(sy_c);
            end
            bu_pkg::ST_MUL_C: begin
                mul_x = px_c - px_a;
                mul_y = YW'(sx_c);
            end
            bu_pkg::ST_MUL_R: begin
                mul_x = XW'(r_crow) - XW'(1);
                mul_y = YW'(sy_c);
            end
            bu_pkg::ST_MUL_K: begin
                mul_x = XW'(r_ccol) - XW'(1);
                mul_y = YW'(sx_c);
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign accept = i_valid && !o_stall;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bu_pkg::ST_IDLE;
            r_scale_x    <= bu_pkg::RST_SCALE;
            r_scale_y    <= bu_pkg::RST_SCALE;
            r_in_cols    <= bu_pkg::RST_DIM;
            r_in_rows    <= bu_pkg::RST_DIM;
            r_row        <= '0;
            r_col        <= '0;
            r_above_left <= '0;
            r_left       <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bu_pkg::CFG_SCALE_X: r_scale_x <= i_cfg_data[SW-1:0];
                    bu_pkg::CFG_SCALE_Y: r_scale_y <= i_cfg_data[SW-1:0];
                    bu_pkg::CFG_IN_COLS: r_in_cols <= i_cfg_data;
                    bu_pkg::CFG_IN_ROWS: r_in_rows <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_row  <= n_row;
                r_col  <= n_col;
                r_left <= i_pixel;
            end
            if (r_state == bu_pkg::ST_FETCH) begin
                r_above_left <= r_above;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // line store, read-first
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above        <= r_line[eff_col];
            r_line[eff_col] <= i_pixel;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            bu_pkg::ST_IDLE: begin
                if (accept) begin
                    r_pa       <= r_above_left;
                    r_pc       <= r_left;
                    r_pd       <= i_pixel;
                    r_crow     <= eff_row;
                    r_ccol     <= eff_col;
                    r_fend     <= at_end;
                    r_has_cell <= has_cell;
                end
            end
            bu_pkg::ST_FETCH: begin
                r_s <= YW'(prod);
                r_r <= '0;
                r_c <= '0;
            end
            bu_pkg::ST_MUL_A: begin
                r_sum    <= UW'(prod);
                r_rowsum <= UW'(prod);
                r_ddl    <= UW'((px_d - px_c) - (px_b - px_a));
            end
            bu_pkg::ST_MUL_B: r_dlt  <= UW'(prod);
            bu_pkg::ST_MUL_C: r_rho  <= UW'(prod);
            bu_pkg::ST_MUL_R: r_orow <= KW'(prod);
            bu_pkg::ST_MUL_K: r_ocol <= KW'(prod);
            bu_pkg::ST_LOAD: begin
                // numerator 2*sum + S, divisor 2*S aligned to the top quotient bit
                r_rem <= {r_sum[DW-2:0], 1'b0} + DW'(r_s);
                r_dsh <= DW'({r_s, {QW{1'b0}}});
                r_bit <= BW'(QW - 1);
            end
            bu_pkg::ST_DIV: begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
                r_bit <= r_bit - BW'(1);
            end
            bu_pkg::ST_OUT: begin
                if (out_load) begin
                    r_value      <= r_q;
                    r_out_row    <= r_orow + KW'(r_r);
                    r_out_col    <= r_ocol + KW'(r_c);
                    r_last_cell  <= cell_last;
                    r_last_frame <= cell_last && r_fend;
                    if (row_end) begin
                        r_c      <= '0;
                        r_r      <= r_r + SW'(1);
                        r_rowsum <= rowsum_next;
                        r_sum    <= rowsum_next;
                        r_dlt    <= r_dlt + r_ddl;
                    end else begin
                        r_c   <= r_c + SW'(1);
                        r_sum <= r_sum + r_dlt;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_valid         = r_ovalid;
    assign o_value         = r_value;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_last_of_cell  = r_last_cell;
    assign o_last_of_frame = r_last_frame;

endmodule
